// ===== design/fwhdm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fwhdm_pkg
// Shared types, register map, reset values and helper functions for the
// four-wheel holonomic drive mixer.
// ----------------------------------------------------------------------------
package fwhdm_pkg;

    // field widths
    localparam int CMD_W    = 16;   // Q4.12 command components
    localparam int LIM_W    = 15;   // clamp limits
    localparam int COEF_W   = 16;   // reciprocal radius and geometry sum
    localparam int CFG_W    = 64;   // widest configuration register
    localparam int IDX_W    = 3;    // configuration register index
    localparam int OUT_W    = 24;   // Q12.12 wheel speeds
    localparam int NWHEEL   = 4;

    // internal datapath widths
    localparam int ROT_W    = 33;   // geometry_sum * yaw
    localparam int SUM_W    = 34;   // vx<<16 +/- vy<<16 +/- rotation
    localparam int PROD_W   = 51;   // k * sum
    localparam int WHL_W    = 27;   // rounded Q12.12 wheel speed
    localparam int TRIM_W   = 28;   // wheel speed plus offset
    localparam int GPROD_W  = 45;   // trimmed speed * gain
    localparam int GOUT_W   = 31;   // rounded gain product

    localparam logic signed [WHL_W-1:0] DEADBAND = 27'sd4;

    // register map
    typedef enum logic [IDX_W-1:0] {
        REG_INV_WHEEL_RADIUS = 3'd0,
        REG_GEOMETRY_SUM     = 3'd1,
        REG_LIMIT_FORWARD    = 3'd2,
        REG_LIMIT_SIDEWAYS   = 3'd3,
        REG_LIMIT_YAW        = 3'd4,
        REG_WHEEL_OFFSETS    = 3'd5,
        REG_WHEEL_GAINS      = 3'd6
    } reg_index_t;

    // wheel positions within the packed offset and gain registers
    typedef enum logic [1:0] {
        WHEEL_FL = 2'd0,
        WHEEL_FR = 2'd1,
        WHEEL_RL = 2'd2,
        WHEEL_RR = 2'd3
    } wheel_t;

    // reset values
    localparam logic [COEF_W-1:0] RST_INV_WHEEL_RADIUS = 16'd5120;
    localparam logic [COEF_W-1:0] RST_GEOMETRY_SUM     = 16'd19661;
    localparam logic [LIM_W-1:0]  RST_LIMIT_FORWARD    = 15'd4096;
    localparam logic [LIM_W-1:0]  RST_LIMIT_SIDEWAYS   = 15'd4096;
    localparam logic [LIM_W-1:0]  RST_LIMIT_YAW        = 15'd12288;
    localparam logic [CFG_W-1:0]  RST_WHEEL_OFFSETS    = 64'h0;
    localparam logic [CFG_W-1:0]  RST_WHEEL_GAINS      = 64'h4000_4000_4000_4000;

    // symmetric clamp of a signed command to [-lim, +lim]
    function automatic logic signed [CMD_W-1:0] clamp_sym(
        input logic signed [CMD_W-1:0] v,
        input logic [LIM_W-1:0]        lim
    );
        logic signed [CMD_W:0] ve;
        logic signed [CMD_W:0] le;
        logic signed [CMD_W:0] res;
        ve = {v[CMD_W-1], v};
        le = {2'b00, lim};
        if (ve > le)
            res = le;
        else if (ve < -le)
            res = -le;
        else
            res = ve;
        return res[CMD_W-1:0];
    endfunction

    // saturate the rounded gain product to the 24-bit output range
    function automatic logic signed [OUT_W-1:0] sat_out(
        input logic signed [GOUT_W-1:0] g
    );
        logic signed [GOUT_W-1:0] hi;
        logic signed [GOUT_W-1:0] lo;
        logic signed [OUT_W-1:0]  res;
        hi = 31'sd8388607;
        lo = -31'sd8388608;
        if (g > hi)
            res = 24'sh7FFFFF;
        else if (g < lo)
            res = 24'sh800000;
        else
            res = g[OUT_W-1:0];
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== design/four_wheel_holonomic_drive_mixer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// four_wheel_holonomic_drive_mixer
// Clamps a body velocity command and mixes it into four wheel speeds with
// deadband, per-wheel offset and per-wheel gain, in a seven-stage pipeline.
// ----------------------------------------------------------------------------
// One item is accepted per clock while the output side keeps taking results.
// Each item passes through the pipeline stages in order: clamp, rotation
// multiply, wheel sums, radius multiply, round/deadband/offset, gain multiply,
// round/saturate. Each stage has its own valid bit and holds only while the
// stage after it is full and stalled, so bubbles close up and input is still
// taken while a finished result waits. Configuration registers are written
// through the write enable; they must only change while no item is in flight.
module four_wheel_holonomic_drive_mixer
    import fwhdm_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,

    input  wire logic                    cfg_we,
    input  wire logic [IDX_W-1:0]        cfg_index,
    input  wire logic [CFG_W-1:0]        cfg_data,

    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic signed [CMD_W-1:0] forward_speed,
    input  wire logic signed [CMD_W-1:0] sideways_speed,
    input  wire logic signed [CMD_W-1:0] yaw_rate,

    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic signed [OUT_W-1:0]      front_left_speed,
    output logic signed [OUT_W-1:0]      front_right_speed,
    output logic signed [OUT_W-1:0]      rear_left_speed,
    output logic signed [OUT_W-1:0]      rear_right_speed
);

    // configuration registers
    logic [COEF_W-1:0] inv_wheel_radius_reg;
    logic [COEF_W-1:0] geometry_sum_reg;
    logic [LIM_W-1:0]  limit_forward_reg;
    logic [LIM_W-1:0]  limit_sideways_reg;
    logic [LIM_W-1:0]  limit_yaw_reg;
    logic [CFG_W-1:0]  wheel_offsets_reg;
    logic [CFG_W-1:0]  wheel_gains_reg;

    // stage valid bits and enables
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic en1, en2, en3, en4, en5, en6, en7;

    // stage payloads
    logic signed [CMD_W-1:0]  vx_reg, vy_reg, wz_reg;
    logic signed [CMD_W-1:0]  vx_next, vy_next, wz_next;
    logic signed [CMD_W-1:0]  vx2_reg, vy2_reg;
    logic signed [ROT_W-1:0]  rot_reg;
    logic signed [ROT_W-1:0]  rot_next;
    logic signed [SUM_W-1:0]  sum_reg   [NWHEEL];
    logic signed [SUM_W-1:0]  sum_next  [NWHEEL];
    logic signed [PROD_W-1:0] prod_reg  [NWHEEL];
    logic signed [PROD_W-1:0] prod_next [NWHEEL];
    logic signed [TRIM_W-1:0] trim_reg  [NWHEEL];
    logic signed [TRIM_W-1:0] trim_next [NWHEEL];
    logic signed [GPROD_W-1:0] gprod_reg  [NWHEEL];
    logic signed [GPROD_W-1:0] gprod_next [NWHEEL];
    logic signed [OUT_W-1:0]  out_reg   [NWHEEL];
    logic signed [OUT_W-1:0]  out_next  [NWHEEL];

    // configuration write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_wheel_radius_reg <= RST_INV_WHEEL_RADIUS;
            geometry_sum_reg     <= RST_GEOMETRY_SUM;
            limit_forward_reg    <= RST_LIMIT_FORWARD;
            limit_sideways_reg   <= RST_LIMIT_SIDEWAYS;
            limit_yaw_reg        <= RST_LIMIT_YAW;
            wheel_offsets_reg    <= RST_WHEEL_OFFSETS;
            wheel_gains_reg      <= RST_WHEEL_GAINS;
        end
        else if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_INV_WHEEL_RADIUS: inv_wheel_radius_reg <= cfg_data[COEF_W-1:0];
                REG_GEOMETRY_SUM:     geometry_sum_reg     <= cfg_data[COEF_W-1:0];
                REG_LIMIT_FORWARD:    limit_forward_reg    <= cfg_data[LIM_W-1:0];
                REG_LIMIT_SIDEWAYS:   limit_sideways_reg   <= cfg_data[LIM_W-1:0];
                REG_LIMIT_YAW:        limit_yaw_reg        <= cfg_data[LIM_W-1:0];
                REG_WHEEL_OFFSETS:    wheel_offsets_reg    <= cfg_data;
                REG_WHEEL_GAINS:      wheel_gains_reg      <= cfg_data;
                default:              ;
            endcase
        end
    end

    // per-stage enables: a stage moves when empty or when the next one moves
    assign en7      = !v7_reg || out_ready;
    assign en6      = !v6_reg || en7;
    assign en5      = !v5_reg || en6;
    assign en4      = !v4_reg || en5;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
            if (en6) v6_reg <= v5_reg;
            if (en7) v7_reg <= v6_reg;
        end
    end

    // stage 1: clamp the command components
    always_comb
    begin
        vx_next = clamp_sym(forward_speed, limit_forward_reg);
        vy_next = clamp_sym(sideways_speed, limit_sideways_reg);
        wz_next = clamp_sym(yaw_rate, limit_yaw_reg);
    end

    // stage 2: rotation term a * wz
    assign rot_next = $signed({1'b0, geometry_sum_reg}) * wz_reg;

    // stage 3: wheel sums in Q.28
    always_comb
    begin
        logic signed [SUM_W-1:0] xs;
        logic signed [SUM_W-1:0] ys;
        logic signed [SUM_W-1:0] rs;
        xs = {{2{vx2_reg[CMD_W-1]}}, vx2_reg, 16'h0000};
        ys = {{2{vy2_reg[CMD_W-1]}}, vy2_reg, 16'h0000};
        rs = {rot_reg[ROT_W-1], rot_reg};
        sum_next[WHEEL_FL] = xs - ys - rs;
        sum_next[WHEEL_FR] = xs + ys + rs;
        sum_next[WHEEL_RL] = xs + ys - rs;
        sum_next[WHEEL_RR] = xs - ys + rs;
    end

    // stage 4: scale by reciprocal wheel radius
    always_comb
    begin
        for (int i = 0; i < NWHEEL; i++)
        begin
            prod_next[i] = $signed({1'b0, inv_wheel_radius_reg}) * sum_reg[i];
        end
    end

    // stage 5: round to Q12.12, deadband, add offset (zero in the deadband)
    always_comb
    begin
        logic signed [PROD_W:0]   rnd;
        logic signed [WHL_W-1:0]  w;
        logic signed [CMD_W-1:0]  off;
        for (int i = 0; i < NWHEEL; i++)
        begin
            rnd = {prod_reg[i][PROD_W-1], prod_reg[i]} + (52'sd1 <<< 23);
            w   = rnd[PROD_W-1:24];
            off = wheel_offsets_reg[16*i +: 16];
            if (w <= DEADBAND && w >= -DEADBAND)
                trim_next[i] = '0;
            else
                trim_next[i] = {w[WHL_W-1], w} + {{(TRIM_W-CMD_W){off[CMD_W-1]}}, off};
        end
    end

    // stage 6: apply wheel gain
    always_comb
    begin
        for (int i = 0; i < NWHEEL; i++)
        begin
            gprod_next[i] = trim_reg[i] * $signed({1'b0, wheel_gains_reg[16*i +: 16]});
        end
    end

    // stage 7: round the gain product and saturate
    always_comb
    begin
        logic signed [GPROD_W:0] grnd;
        for (int i = 0; i < NWHEEL; i++)
        begin
            grnd        = {gprod_reg[i][GPROD_W-1], gprod_reg[i]} + (46'sd1 <<< 13);
            out_next[i] = sat_out(grnd[GPROD_W-1:14]);
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            vx_reg <= vx_next;
            vy_reg <= vy_next;
            wz_reg <= wz_next;
        end
        if (en2)
        begin
            vx2_reg <= vx_reg;
            vy2_reg <= vy_reg;
            rot_reg <= rot_next;
        end
        for (int i = 0; i < NWHEEL; i++)
        begin
            if (en3) sum_reg[i]   <= sum_next[i];
            if (en4) prod_reg[i]  <= prod_next[i];
            if (en5) trim_reg[i]  <= trim_next[i];
            if (en6) gprod_reg[i] <= gprod_next[i];
            if (en7) out_reg[i]   <= out_next[i];
        end
    end

    // outputs
    assign out_valid         = v7_reg;
    assign front_left_speed  = out_reg[WHEEL_FL];
    assign front_right_speed = out_reg[WHEEL_FR];
    assign rear_left_speed   = out_reg[WHEEL_RL];
    assign rear_right_speed  = out_reg[WHEEL_RR];

`ifndef SYNTHESIS
    // input only stalls when every stage is full behind a stalled output
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready && v1_reg && v6_reg))
        else $error("input stalled while pipeline has room");

    // a new result only arrives from the last internal stage
    a_out_from_stage6: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(v6_reg))
        else $error("result appeared without a source item");

    // a held result keeps its front-left and rear-right values while the output is stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(front_left_speed) && $stable(rear_right_speed))
        else $error("stalled result changed");
`endif

endmodule
`default_nettype wire

// ===== tb/four_wheel_holonomic_drive_mixer_test.sv =====
// ----------------------------------------------------------------------------
// four_wheel_holonomic_drive_mixer_test
// Self-checking bench for the drive mixer. Body velocity commands go in
// through a valid/ready channel and wheel speed results come back on a second
// one. A scoreboard class computes each command's four wheel speeds in 64-bit
// integer arithmetic from its own copy of the registers and queues them. Every
// result is checked in order against that queue. Directed corner commands
// come first, then random commands under several register settings. Both
// sides idle at random, and there is one long output stall.
// ----------------------------------------------------------------------------
module four_wheel_holonomic_drive_mixer_test;
    import fwhdm_pkg::*;

    localparam int          PIPE_DEPTH   = 7;
    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int          PHASE_ITEMS  = 125;
    localparam int          NUM_PHASES   = 10;
    localparam int          HOLD_PHASE   = 2;
    localparam longint      DEADBAND_LSB = 64'sd4;
    localparam longint      ROUND_24     = 64'sd8388608;
    localparam longint      ROUND_14     = 64'sd8192;
    localparam longint      OUT_HI       = 64'sd8388607;
    localparam longint      OUT_LO       = -64'sd8388608;

    // index past the end of the register map, writes to it are dropped
    localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

    // wheel speeds of one result, front-left in the low bits
    typedef logic [NWHEEL-1:0][OUT_W-1:0] wheel_speeds_t;

    typedef struct {
        logic [COEF_W-1:0] radius;
        logic [COEF_W-1:0] geometry;
        logic [LIM_W-1:0]  lim_fwd;
        logic [LIM_W-1:0]  lim_side;
        logic [LIM_W-1:0]  lim_yaw;
        logic [CFG_W-1:0]  offsets;
        logic [CFG_W-1:0]  gains;
    } mixer_settings_t;

    // predicts wheel speeds for accepted commands and checks results in order
    class wheel_speed_board;
        logic [COEF_W-1:0] radius_k;
        logic [COEF_W-1:0] geometry;
        logic [LIM_W-1:0]  lim_fwd;
        logic [LIM_W-1:0]  lim_side;
        logic [LIM_W-1:0]  lim_yaw;
        logic [CFG_W-1:0]  offsets;
        logic [CFG_W-1:0]  gains;
        wheel_speeds_t     expected_speeds[$];
        int unsigned       commands_seen;
        int unsigned       results_seen;
        int unsigned       mismatches;
        string             wheel_label [NWHEEL];

        function new();
            radius_k      = RST_INV_WHEEL_RADIUS;
            geometry      = RST_GEOMETRY_SUM;
            lim_fwd       = RST_LIMIT_FORWARD;
            lim_side      = RST_LIMIT_SIDEWAYS;
            lim_yaw       = RST_LIMIT_YAW;
            offsets       = RST_WHEEL_OFFSETS;
            gains         = RST_WHEEL_GAINS;
            commands_seen = 0;
            results_seen  = 0;
            mismatches    = 0;
            wheel_label   = '{"front_left", "front_right", "rear_left", "rear_right"};
        endfunction

        // writes to the narrow registers keep only the low bits of the data
        function void set_register(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_INV_WHEEL_RADIUS: radius_k = data[COEF_W-1:0];
                REG_GEOMETRY_SUM:     geometry = data[COEF_W-1:0];
                REG_LIMIT_FORWARD:    lim_fwd  = data[LIM_W-1:0];
                REG_LIMIT_SIDEWAYS:   lim_side = data[LIM_W-1:0];
                REG_LIMIT_YAW:        lim_yaw  = data[LIM_W-1:0];
                REG_WHEEL_OFFSETS:    offsets  = data;
                REG_WHEEL_GAINS:      gains    = data;
                default: ;
            endcase
        endfunction

        function longint clamp_cmd(logic signed [CMD_W-1:0] v, logic [LIM_W-1:0] lim);
            longint l;
            longint c;
            l = lim;
            c = v;
            if (c > l)
                c = l;
            else if (c < -l)
                c = -l;
            return c;
        endfunction

        // radius scale, deadband, offset, gain and saturation of one wheel
        function logic [OUT_W-1:0] wheel_speed(longint sum, int idx);
            longint                  k;
            longint                  w;
            longint                  off;
            longint                  gain;
            longint                  g;
            logic signed [CMD_W-1:0] off_q;
            k = radius_k;
            w = (sum * k + ROUND_24) >>> 24;
            if (w <= DEADBAND_LSB && w >= -DEADBAND_LSB)
                return '0;
            off_q = offsets[idx*16 +: 16];
            off   = off_q;
            gain  = gains[idx*16 +: 16];
            g = ((w + off) * gain + ROUND_14) >>> 14;
            if (g > OUT_HI)
                g = OUT_HI;
            else if (g < OUT_LO)
                g = OUT_LO;
            return g[OUT_W-1:0];
        endfunction

        function wheel_speeds_t mix_wheels(logic signed [CMD_W-1:0] fwd,
                                           logic signed [CMD_W-1:0] side,
                                           logic signed [CMD_W-1:0] yaw);
            longint        vx;
            longint        vy;
            longint        wz;
            longint        x;
            longint        y;
            longint        r;
            longint        sums [NWHEEL];
            wheel_speeds_t speeds;
            vx = clamp_cmd(fwd, lim_fwd);
            vy = clamp_cmd(side, lim_side);
            wz = clamp_cmd(yaw, lim_yaw);
            x  = vx * 65536;
            y  = vy * 65536;
            r  = geometry;
            r  = r * wz;
            sums[WHEEL_FL] = x - y - r;
            sums[WHEEL_FR] = x + y + r;
            sums[WHEEL_RL] = x + y - r;
            sums[WHEEL_RR] = x - y + r;
            for (int i = 0; i < NWHEEL; i++)
                speeds[i] = wheel_speed(sums[i], i);
            return speeds;
        endfunction

        function void note_command(logic signed [CMD_W-1:0] fwd,
                                   logic signed [CMD_W-1:0] side,
                                   logic signed [CMD_W-1:0] yaw);
            expected_speeds.push_back(mix_wheels(fwd, side, yaw));
            commands_seen++;
        endfunction

        function void check_wheels(wheel_speeds_t got);
            wheel_speeds_t want;
            if (expected_speeds.size() == 0) begin
                $display("%0t: result with no command pending, fl %0d fr %0d rl %0d rr %0d",
                         $time, $signed(got[WHEEL_FL]), $signed(got[WHEEL_FR]),
                         $signed(got[WHEEL_RL]), $signed(got[WHEEL_RR]));
                mismatches++;
                return;
            end
            want = expected_speeds.pop_front();
            results_seen++;
            for (int i = 0; i < NWHEEL; i++) begin
                if (got[i] !== want[i]) begin
                    $display("%0t: %s speed expected %0d, actual %0d", $time,
                             wheel_label[i], $signed(want[i]), $signed(got[i]));
                    mismatches++;
                end
            end
        endfunction

        function int unsigned pending();
            return expected_speeds.size();
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     cfg_we;
    logic [IDX_W-1:0]         cfg_index;
    logic [CFG_W-1:0]         cfg_data;
    logic                     in_valid;
    logic                     in_ready;
    logic signed [CMD_W-1:0]  forward_speed;
    logic signed [CMD_W-1:0]  sideways_speed;
    logic signed [CMD_W-1:0]  yaw_rate;
    logic                     out_valid;
    logic                     out_ready;
    logic signed [OUT_W-1:0]  front_left_speed;
    logic signed [OUT_W-1:0]  front_right_speed;
    logic signed [OUT_W-1:0]  rear_left_speed;
    logic signed [OUT_W-1:0]  rear_right_speed;

    wheel_speed_board board = new();
    bit               tx_idle_on;
    bit               rx_idle_on;
    bit               hold_request;
    int unsigned      cycles;
    int unsigned      settings_applied;

    four_wheel_holonomic_drive_mixer i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .forward_speed     (forward_speed),
        .sideways_speed    (sideways_speed),
        .yaw_rate          (yaw_rate),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .front_left_speed  (front_left_speed),
        .front_right_speed (front_right_speed),
        .rear_left_speed   (rear_left_speed),
        .rear_right_speed  (rear_right_speed)
    );

    // clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // idle stretch lengths, mostly short with the odd long one
    function automatic int unsigned idle_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    // command component: full range, moderate or near zero
    function automatic logic signed [CMD_W-1:0] random_component();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return CMD_W'($urandom);
        if (r < 8)
            return CMD_W'($urandom_range(0, 16384) - 8192);
        return CMD_W'($urandom_range(0, 16) - 8);
    endfunction

    function automatic logic [LIM_W-1:0] random_limit();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        if (r < 4)
            return '1;
        return LIM_W'($urandom_range(1, 32767));
    endfunction

    function automatic mixer_settings_t random_settings();
        mixer_settings_t s;
        int unsigned     r;
        r = $urandom_range(0, 9);
        if (r == 0)
            s.radius = '1;
        else if (r == 1)
            s.radius = COEF_W'($urandom_range(0, 65535));
        else
            s.radius = COEF_W'($urandom_range(64, 6000));
        s.geometry = COEF_W'($urandom_range(0, 65535));
        s.lim_fwd  = random_limit();
        s.lim_side = random_limit();
        s.lim_yaw  = random_limit();
        s.offsets  = {$urandom, $urandom};
        s.gains    = {$urandom, $urandom};
        return s;
    endfunction

    function automatic mixer_settings_t reset_settings();
        mixer_settings_t s;
        s.radius   = RST_INV_WHEEL_RADIUS;
        s.geometry = RST_GEOMETRY_SUM;
        s.lim_fwd  = RST_LIMIT_FORWARD;
        s.lim_side = RST_LIMIT_SIDEWAYS;
        s.lim_yaw  = RST_LIMIT_YAW;
        s.offsets  = RST_WHEEL_OFFSETS;
        s.gains    = RST_WHEEL_GAINS;
        return s;
    endfunction

    // random junk above a narrow register's width, the block must drop it
    function automatic logic [CFG_W-1:0] with_junk(logic [CFG_W-1:0] v, int width);
        logic [CFG_W-1:0] mask;
        logic [CFG_W-1:0] r;
        mask = (64'h1 << width) - 64'h1;
        r    = {$urandom, $urandom};
        return (r & ~mask) | (v & mask);
    endfunction

    task automatic write_register(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        board.set_register(idx, data);
    endtask

    // all registers back to back, plus one write outside the map
    task automatic apply_settings(input mixer_settings_t s);
        write_register(REG_INV_WHEEL_RADIUS, with_junk(s.radius, COEF_W));
        write_register(REG_GEOMETRY_SUM, with_junk(s.geometry, COEF_W));
        write_register(REG_LIMIT_FORWARD, with_junk(s.lim_fwd, LIM_W));
        write_register(REG_LIMIT_SIDEWAYS, with_junk(s.lim_side, LIM_W));
        write_register(REG_UNUSED, {$urandom, $urandom});
        write_register(REG_LIMIT_YAW, with_junk(s.lim_yaw, LIM_W));
        write_register(REG_WHEEL_OFFSETS, s.offsets);
        write_register(REG_WHEEL_GAINS, s.gains);
        cfg_we <= 1'b0;
        settings_applied++;
    endtask

    // hold the command until the block takes it
    task automatic send_command(input logic signed [CMD_W-1:0] fwd,
                                input logic signed [CMD_W-1:0] side,
                                input logic signed [CMD_W-1:0] yaw);
        in_valid       <= 1'b1;
        forward_speed  <= fwd;
        sideways_speed <= side;
        yaw_rate       <= yaw;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_command(fwd, side, yaw);
    endtask

    task automatic offer_command(input logic signed [CMD_W-1:0] fwd,
                                 input logic signed [CMD_W-1:0] side,
                                 input logic signed [CMD_W-1:0] yaw);
        int unsigned gap;
        send_command(fwd, side, yaw);
        gap = (tx_idle_on && $urandom_range(0, 99) < 30) ? idle_length() : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop offering and wait until every queued result has come back
    task automatic finish_batch();
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    // result side: check accepted items, stall at random or on request
    initial
    begin
        int unsigned stall_left;
        stall_left = 0;
        out_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (out_valid && out_ready)
                board.check_wheels({rear_right_speed, rear_left_speed,
                                    front_right_speed, front_left_speed});
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = HOLD_CYCLES;
            end
            if (stall_left == 0 && rx_idle_on && $urandom_range(0, 99) < 25)
                stall_left = idle_length();
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // run limit
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
        $display("four_wheel_holonomic_drive_mixer_test failed");
        $finish;
    end

    // stimulus
    initial
    begin
        mixer_settings_t s;
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_index        <= REG_INV_WHEEL_RADIUS;
        cfg_data         <= '0;
        in_valid         <= 1'b0;
        forward_speed    <= '0;
        sideways_speed   <= '0;
        yaw_rate         <= '0;
        tx_idle_on       = 1'b0;
        rx_idle_on       = 1'b0;
        hold_request     = 1'b0;
        settings_applied = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values: zero, full scale, clamping, pure axes
        offer_command(16'sd0, 16'sd0, 16'sd0);
        offer_command(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        offer_command(16'sh8000, 16'sh8000, 16'sh8000);
        offer_command(16'sd4096, 16'sd0, 16'sd0);
        offer_command(16'sd0, -16'sd4096, 16'sd0);
        offer_command(16'sd0, 16'sd0, 16'sd12288);
        offer_command(-16'sd4096, 16'sd4096, -16'sd12288);
        finish_batch();

        // unit radius, no rotation: deadband edges, offsets, odd gains
        s = '{radius: 16'd256, geometry: 16'd0, lim_fwd: '1, lim_side: '1, lim_yaw: '1,
              offsets: 64'h8000_7FFF_FF9C_0064, gains: 64'hFFFF_0000_2000_8000};
        apply_settings(s);
        offer_command(16'sd4, 16'sd0, 16'sd0);
        offer_command(16'sd5, 16'sd0, 16'sd0);
        offer_command(-16'sd4, 16'sd0, 16'sd0);
        offer_command(-16'sd5, 16'sd0, 16'sd0);
        offer_command(16'sd3, -16'sd2, 16'sd0);
        offer_command(16'sh8000, 16'sd0, 16'sd0);
        finish_batch();

        // everything at full scale: saturation both ways
        s = '{radius: '1, geometry: '1, lim_fwd: '1, lim_side: '1, lim_yaw: '1,
              offsets: 64'h7FFF_8000_7FFF_8000, gains: '1};
        apply_settings(s);
        offer_command(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        offer_command(16'sh8000, 16'sh8000, 16'sh8000);
        offer_command(16'sh7FFF, 16'sh8000, 16'sd0);
        offer_command(16'sd1, 16'sd0, 16'sd0);
        finish_batch();

        // zero limits and coefficients
        s = '{radius: '0, geometry: '0, lim_fwd: '0, lim_side: '0, lim_yaw: '0,
              offsets: '0, gains: '0};
        apply_settings(s);
        offer_command(16'sh7FFF, 16'sh8000, 16'sd12345);
        offer_command(-16'sd1, 16'sd1, -16'sd1);
        finish_batch();

        // random commands under changing settings and idling patterns
        for (int p = 0; p < NUM_PHASES; p++) begin
            tx_idle_on = (p % 4 == 1) || (p % 4 == 3);
            rx_idle_on = (p % 4 >= 2);
            if (p == 0)
                s = reset_settings();
            else if (p == 1)
                s = '{radius: '1, geometry: '1, lim_fwd: '1, lim_side: '1, lim_yaw: '1,
                      offsets: {$urandom, $urandom}, gains: '1};
            else
                s = random_settings();
            apply_settings(s);
            if (p == HOLD_PHASE)
                hold_request = 1'b1;
            repeat (PHASE_ITEMS)
                offer_command(random_component(), random_component(), random_component());
            finish_batch();
        end

        repeat (4 * PIPE_DEPTH) @(posedge clk);
        $display("%0d commands sent, %0d results checked under %0d register settings",
                 board.commands_seen, board.results_seen, settings_applied);
        $display("covered deadband, saturation, zero limits and a %0d-cycle output stall",
                 HOLD_CYCLES);
        if (board.mismatches == 0)
            $display("four_wheel_holonomic_drive_mixer_test passed");
        else
            $display("four_wheel_holonomic_drive_mixer_test failed");
        $finish;
    end

endmodule
